// ===== hdl/tilt_angle_averaging_servo_drive_assert.svh =====
// assertion macros shared by the tilt servo drive rtl
`ifndef TILT_ANGLE_AVERAGING_SERVO_DRIVE_ASSERT_SVH
`define TILT_ANGLE_AVERAGING_SERVO_DRIVE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TASD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TASD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tasd_pkg.sv =====
// types, constants and the arctangent table of the tilt servo drive
package tasd_pkg;

	localparam int ACCEL_W      = 16;
	localparam int ANGLE_W      = 8;
	localparam int MAG_W        = ACCEL_W + 1;
	localparam int CX_W         = 28;
	localparam int ACC_W        = 16;
	localparam int CORDIC_STEPS = 15;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	// window length, a power of two
	localparam int WINDOW       = 8;
	localparam int WINDOW_LG    = $clog2(WINDOW);
	localparam int SUM_W        = ANGLE_W + WINDOW_LG;
	localparam int DRV_W        = SUM_W + 1;

	localparam logic signed [ACC_W-1:0] ANGLE_MAX_Q8 = 16'sd23040;
	localparam logic [ANGLE_W-1:0]      DEG_90       = 8'd90;
	localparam logic [ANGLE_W-1:0]      SERVO_MAX    = 8'd180;
	localparam logic [ANGLE_W-1:0]      NEUTRAL_RST  = 8'd90;

	typedef logic signed [ACCEL_W-1:0] accel_t;
	typedef logic signed [ANGLE_W-1:0] tilt_t;
	typedef logic [ANGLE_W-1:0]        angle_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic [STEP_W-1:0]         step_t;

	typedef struct packed {
		tilt_t x;
		tilt_t y;
	} tilt_pair_t;

	typedef struct packed {
		angle_t x;
		angle_t y;
	} drive_pair_t;

	// atan(2^-i) in q8 degrees, scale 180/3.1415
	function automatic acc_t atan_q8(input step_t i);
		acc_t t;
		case (i)
			4'd0:    t = 16'sd11520;
			4'd1:    t = 16'sd6801;
			4'd2:    t = 16'sd3593;
			4'd3:    t = 16'sd1824;
			4'd4:    t = 16'sd916;
			4'd5:    t = 16'sd458;
			4'd6:    t = 16'sd229;
			4'd7:    t = 16'sd115;
			4'd8:    t = 16'sd57;
			4'd9:    t = 16'sd29;
			4'd10:   t = 16'sd14;
			4'd11:   t = 16'sd7;
			4'd12:   t = 16'sd4;
			4'd13:   t = 16'sd2;
			4'd14:   t = 16'sd1;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ===== hdl/tilt_angle_averaging_servo_drive.sv =====
// top level: sequencer around the shared cordic, averaging and output register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in      | sink      | in_valid/in_stall   | accel_x, accel_y, accel_z
//  out     | source    | out_valid/out_stall | servo_x_angle, servo_y_angle
//  cfg     | sink      | cfg_we              | cfg_wdata (neutral angle)
//
//  an item runs from accept to the next accept through these steps: the
//  single cordic runs load, 15 iterations and done for each axis, x then
//  y, then a ring update, a load of the output register when it is free,
//  and an idle step that takes the next item; items do not overlap.
//  reset clears the rings, sums and the window position at once, and the
//  neutral angle returns to 90. a stalled result holds in the output
//  register; the sequencer waits in its last step only when a new result
//  finds that register still full.
`include "tilt_angle_averaging_servo_drive_assert.svh"

module tilt_angle_averaging_servo_drive (
	input  logic             clk,
	input  logic             arst_n,
	// config
	input  logic             cfg_we,
	input  tasd_pkg::angle_t cfg_wdata,
	// input items
	input  logic             in_valid,
	output logic             in_stall,
	input  tasd_pkg::accel_t accel_x,
	input  tasd_pkg::accel_t accel_y,
	input  tasd_pkg::accel_t accel_z,
	// result items
	output logic             out_valid,
	input  logic             out_stall,
	output tasd_pkg::angle_t servo_x_angle,
	output tasd_pkg::angle_t servo_y_angle
);
	import tasd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START_X,
		ST_WAIT_X,
		ST_START_Y,
		ST_WAIT_Y,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic        out_valid_q;
	angle_t      neutral_q;
	angle_t      servo_x_q;
	angle_t      servo_y_q;

	// captured sample and per-axis tilts
	accel_t      ax_q;
	accel_t      ay_q;
	accel_t      az_q;
	logic        z_pos_q;
	tilt_pair_t  tilts_q;

	logic        in_take;
	logic        cx_start;
	logic        cx_done;
	accel_t      cx_axis;
	tilt_t       cx_tilt;
	logic        avg_update;
	drive_pair_t drive;
	logic        out_free;
	logic        out_load;

	assign in_take    = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign cx_start   = (state_q == ST_START_X) || (state_q == ST_START_Y);
	assign cx_axis    = (state_q == ST_START_Y) ? ay_q : ax_q;
	assign avg_update = (state_q == ST_UPDATE);
	// output register can take a result this cycle
	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = (state_q == ST_EMIT) && z_pos_q && out_free;

	// neutral angle register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			neutral_q <= NEUTRAL_RST;
		else if (cfg_we)
			neutral_q <= cfg_wdata;
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_take)
						state_q <= ST_START_X;
				end
				ST_START_X: state_q <= ST_WAIT_X;
				ST_WAIT_X: begin
					if (cx_done)
						state_q <= ST_START_Y;
				end
				ST_START_Y: state_q <= ST_WAIT_Y;
				ST_WAIT_Y: begin
					if (cx_done)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: state_q <= ST_EMIT;
				ST_EMIT: begin
					// samples with z <= 0 are averaged in but give no result
					if (!z_pos_q || out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample capture, tilt capture and result payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			ax_q    <= accel_x;
			ay_q    <= accel_y;
			az_q    <= accel_z;
			z_pos_q <= !accel_z[ACCEL_W-1] && (accel_z != '0);
		end
		if (cx_done && state_q == ST_WAIT_X)
			tilts_q.x <= cx_tilt;
		if (cx_done && state_q == ST_WAIT_Y)
			tilts_q.y <= cx_tilt;
		if (out_load) begin
			servo_x_q <= drive.x;
			servo_y_q <= drive.y;
		end
	end

	tasd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cx_start),
		.axis   (cx_axis),
		.z      (az_q),
		.done   (cx_done),
		.tilt   (cx_tilt)
	);

	tasd_avg u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (avg_update),
		.tilts   (tilts_q),
		.neutral (neutral_q),
		.drive   (drive)
	);

	assign out_valid     = out_valid_q;
	assign servo_x_angle = servo_x_q;
	assign servo_y_angle = servo_y_q;

	`TASD_ASSERT_IMP(a_done_in_wait, clk, arst_n, cx_done, state_q == ST_WAIT_X || state_q == ST_WAIT_Y, "cordic done outside a wait step")
	`TASD_ASSERT_NXT(a_take_starts, clk, arst_n, in_take, state_q == ST_START_X, "accepted item did not start the x run")
	`TASD_ASSERT_IMP(a_result_zpos, clk, arst_n, $rose(out_valid_q), z_pos_q, "result raised for a sample with z <= 0")

endmodule

// ===== hdl/tasd_cordic.sv =====
// iterative vectoring cordic giving one whole-degree tilt per run
`include "tilt_angle_averaging_servo_drive_assert.svh"

module tasd_cordic (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tasd_pkg::accel_t axis,
	input  tasd_pkg::accel_t z,
	output logic             done,
	output tasd_pkg::tilt_t  tilt
);
	import tasd_pkg::*;

	localparam step_t LAST_STEP = step_t'(CORDIC_STEPS - 1);

	logic                   busy_q;
	logic                   done_q;
	step_t                  step_q;
	logic signed [CX_W-1:0] cx_q;
	logic signed [CX_W-1:0] cy_q;
	acc_t                   acc_q;
	logic                   neg_q;
	logic                   a_zero_q;
	logic                   z_zero_q;

	logic [MAG_W-1:0]       ext_a;
	logic [MAG_W-1:0]       ext_z;
	logic [MAG_W-1:0]       mag_a;
	logic [MAG_W-1:0]       mag_z;
	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	acc_t                   t_step;
	acc_t                   acc_c;
	angle_t                 deg;

	always_comb begin
		ext_a  = {axis[ACCEL_W-1], axis};
		ext_z  = {z[ACCEL_W-1], z};
		mag_a  = axis[ACCEL_W-1] ? (~ext_a + MAG_W'(1)) : ext_a;
		mag_z  = z[ACCEL_W-1] ? (~ext_z + MAG_W'(1)) : ext_z;
		dx     = cy_q >>> step_q;
		dy     = cx_q >>> step_q;
		t_step = atan_q8(step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + step_t'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			cx_q     <= signed'(CX_W'({mag_z, 8'd0}));
			cy_q     <= signed'(CX_W'({mag_a, 8'd0}));
			acc_q    <= '0;
			neg_q    <= axis[ACCEL_W-1] ^ z[ACCEL_W-1];
			a_zero_q <= (axis == '0);
			z_zero_q <= (z == '0);
		end else if (busy_q) begin
			if (cy_q > 0) begin
				cx_q  <= cx_q + dx;
				cy_q  <= cy_q - dy;
				acc_q <= acc_q + t_step;
			end else begin
				cx_q  <= cx_q - dx;
				cy_q  <= cy_q + dy;
				acc_q <= acc_q - t_step;
			end
		end
	end

	// clamp to 0..90 deg, drop the fraction, apply sign
	always_comb begin
		if (acc_q < 0)
			acc_c = '0;
		else if (acc_q > ANGLE_MAX_Q8)
			acc_c = ANGLE_MAX_Q8;
		else
			acc_c = acc_q;
		deg = z_zero_q ? DEG_90 : angle_t'(acc_c[ACC_W-1:8]);
		if (a_zero_q)
			tilt = '0;
		else if (neg_q)
			tilt = -signed'(deg);
		else
			tilt = signed'(deg);
	end

	assign done = done_q;

	`TASD_ASSERT_IMP(a_start_idle, clk, arst_n, start, !busy_q, "cordic started while busy")
	`TASD_ASSERT_NXT(a_last_done, clk, arst_n, busy_q && step_q == LAST_STEP, done_q && !busy_q, "cordic missed done after last step")
	`TASD_ASSERT_IMP(a_step_range, clk, arst_n, busy_q, step_q <= LAST_STEP, "cordic step beyond table")
	`TASD_ASSERT_IMP(a_done_quiet, clk, arst_n, done_q, !busy_q, "cordic done while still iterating")

endmodule

// ===== hdl/tasd_avg.sv =====
// tilt rings, running sums and servo drive computation
module tasd_avg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  update,
	input  tasd_pkg::tilt_pair_t  tilts,
	input  tasd_pkg::angle_t      neutral,
	output tasd_pkg::drive_pair_t drive
);
	import tasd_pkg::*;

	localparam logic [WINDOW_LG-1:0] POS_LAST = WINDOW_LG'(WINDOW - 1);

	tilt_t                   ring_x_q [WINDOW];
	tilt_t                   ring_y_q [WINDOW];
	logic [WINDOW_LG-1:0]    pos_q;
	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_x_q[i] <= '0;
				ring_y_q[i] <= '0;
			end
			pos_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (update) begin
			sum_x_q         <= sum_x_q + SUM_W'(tilts.x) - SUM_W'(ring_x_q[pos_q]);
			sum_y_q         <= sum_y_q + SUM_W'(tilts.y) - SUM_W'(ring_y_q[pos_q]);
			ring_x_q[pos_q] <= tilts.x;
			ring_y_q[pos_q] <= tilts.y;
			pos_q           <= (pos_q == POS_LAST) ? '0 : pos_q + WINDOW_LG'(1);
		end
	end

	// average truncated toward zero, plus neutral, clamped 0..180
	function automatic angle_t servo(input logic signed [SUM_W-1:0] sum, input angle_t n);
		logic signed [SUM_W-1:0] biased;
		logic signed [SUM_W-1:0] avg;
		logic signed [DRV_W-1:0] v;
		biased = (sum < 0) ? sum + SUM_W'(WINDOW - 1) : sum;
		avg    = biased >>> WINDOW_LG;
		v      = DRV_W'(avg) + signed'(DRV_W'(n));
		if (v < 0)
			return '0;
		else if (v > signed'(DRV_W'(SERVO_MAX)))
			return SERVO_MAX;
		else
			return angle_t'(v);
	endfunction

	assign drive.x = servo(sum_x_q, neutral);
	assign drive.y = servo(sum_y_q, neutral);

endmodule
